// ----- src/asie_pkg.sv -----
// types, constants and the condition check for the arm subset execute block
// no dependencies; compiled first
`timescale 1ns / 1ps

package asie_pkg;

   localparam int unsigned XLEN    = 32;
   localparam int unsigned RF_AW   = 4;
   localparam int unsigned SVC_W   = 24;

   localparam logic [RF_AW-1:0] PC_IDX = 4'hF;
   localparam logic [RF_AW-1:0] LR_IDX = 4'hE;

   localparam logic REQ_INSTR = 1'b0;
   localparam logic REQ_DATA  = 1'b1;

   localparam logic [1:0] COST_NONE   = 2'd0;
   localparam logic [1:0] COST_NORMAL = 2'd1;
   localparam logic [1:0] COST_MEM    = 2'd2;
   localparam logic [1:0] COST_BRANCH = 2'd3;

   localparam logic [3:0] OP_SUB = 4'h2;
   localparam logic [3:0] OP_ADD = 4'h4;
   localparam logic [3:0] OP_CMP = 4'hA;
   localparam logic [3:0] OP_MOV = 4'hD;

   localparam logic [3:0] COND_EQ = 4'h0;
   localparam logic [3:0] COND_NE = 4'h1;
   localparam logic [3:0] COND_CS = 4'h2;
   localparam logic [3:0] COND_CC = 4'h3;
   localparam logic [3:0] COND_MI = 4'h4;
   localparam logic [3:0] COND_PL = 4'h5;
   localparam logic [3:0] COND_VS = 4'h6;
   localparam logic [3:0] COND_VC = 4'h7;
   localparam logic [3:0] COND_HI = 4'h8;
   localparam logic [3:0] COND_LS = 4'h9;
   localparam logic [3:0] COND_GE = 4'hA;
   localparam logic [3:0] COND_LT = 4'hB;
   localparam logic [3:0] COND_GT = 4'hC;
   localparam logic [3:0] COND_LE = 4'hD;
   localparam logic [3:0] COND_AL = 4'hE;

   localparam logic [XLEN-1:0] BX_MASK   = 32'h0FFF_FFD0;
   localparam logic [XLEN-1:0] BX_PATT   = 32'h012F_FF10;
   localparam logic [XLEN-1:0] SVC_MASK  = 32'h0F00_0000;
   localparam logic [XLEN-1:0] BR_MASK   = 32'h0E00_0000;
   localparam logic [XLEN-1:0] BR_PATT   = 32'h0A00_0000;
   localparam logic [XLEN-1:0] CLS_MASK  = 32'h0C00_0000;
   localparam logic [XLEN-1:0] MEM_PATT  = 32'h0400_0000;
   localparam logic [7:0]      T_SVC_HI  = 8'hDF;
   localparam logic [4:0]      T_B_HI    = 5'b11100;

   typedef struct packed {
      logic [XLEN-1:0]  next_pc;
      logic             thumb_mode;
      logic [1:0]       cycle_cost;
      logic             mem_read;
      logic             mem_write;
      logic [XLEN-1:0]  mem_address;
      logic [XLEN-1:0]  store_data;
      logic             svc_request;
      logic [SVC_W-1:0] svc_number;
      logic [3:0]       flags_nzcv;
      logic             protocol_error;
   } rsp_word_type;

   typedef struct packed {
      logic [XLEN-1:0]  pc;
      logic [3:0]       flags;
      logic             thumb;
      logic             load_pending;
      logic [RF_AW-1:0] load_dest;
      logic             rf_we;
      logic [RF_AW-1:0] rf_waddr;
      logic [XLEN-1:0]  rf_wdata;
   } state_upd_type;

   function automatic logic cond_pass(input logic [3:0] cond, input logic [3:0] nzcv);
      logic n, z, c, v, res;
      n = nzcv[3];
      z = nzcv[2];
      c = nzcv[1];
      v = nzcv[0];
      case (cond)
         COND_EQ: res = z;
         COND_NE: res = !z;
         COND_CS: res = c;
         COND_CC: res = !c;
         COND_MI: res = n;
         COND_PL: res = !n;
         COND_VS: res = v;
         COND_VC: res = !v;
         COND_HI: res = c && !z;
         COND_LS: res = !c || z;
         COND_GE: res = (n == v);
         COND_LT: res = (n != v);
         COND_GT: res = !z && (n == v);
         COND_LE: res = z || (n != v);
         COND_AL: res = 1'b1;
         default: res = 1'b0;
      endcase
      return res;
   endfunction

endpackage

// ----- src/asie_if.sv -----
// valid/ready channel interfaces for request and response words
// depends on asie_pkg
`timescale 1ns / 1ps

interface asie_req_if;
   import asie_pkg::*;
   logic            valid;
   logic            ready;
   logic            req_type;
   logic [XLEN-1:0] instruction;
   logic [XLEN-1:0] load_data;

   modport source (output valid, req_type, instruction, load_data, input ready);
   modport sink   (input valid, req_type, instruction, load_data, output ready);
endinterface

interface asie_rsp_if;
   import asie_pkg::*;
   logic             valid;
   logic             ready;
   logic [XLEN-1:0]  next_pc;
   logic             thumb_mode;
   logic [1:0]       cycle_cost;
   logic             mem_read;
   logic             mem_write;
   logic [XLEN-1:0]  mem_address;
   logic [XLEN-1:0]  store_data;
   logic             svc_request;
   logic [SVC_W-1:0] svc_number;
   logic [3:0]       flags_nzcv;
   logic             protocol_error;

   modport source (output valid, next_pc, thumb_mode, cycle_cost, mem_read, mem_write,
                   mem_address, store_data, svc_request, svc_number, flags_nzcv,
                   protocol_error, input ready);
   modport sink   (input valid, next_pc, thumb_mode, cycle_cost, mem_read, mem_write,
                   mem_address, store_data, svc_request, svc_number, flags_nzcv,
                   protocol_error, output ready);
endinterface

// ----- src/asie_ram.sv -----
// generic ram, one write port and two registered read ports
// no dependencies
`timescale 1ns / 1ps

module asie_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_a <= mem_ff[raddr_a];
         rdata_b <= mem_ff[raddr_b];
      end
   end

endmodule

// ----- src/asie_exec.sv -----
// execute logic: decodes one word against current state, forms the
// response word and the state update; depends on asie_pkg
`timescale 1ns / 1ps

module asie_exec import asie_pkg::*; (
   input  logic             req_type,
   input  logic [XLEN-1:0]  instruction,
   input  logic [XLEN-1:0]  load_data,
   input  logic [XLEN-1:0]  opa,
   input  logic [XLEN-1:0]  opb,
   input  logic [XLEN-1:0]  pc,
   input  logic [3:0]       flags,
   input  logic             thumb,
   input  logic             load_pending,
   input  logic [RF_AW-1:0] load_dest,
   output rsp_word_type     rsp,
   output state_upd_type    upd
);

   logic [XLEN-1:0]  w;
   logic [RF_AW-1:0] rn, rd, rm;
   logic [3:0]       op;
   logic [XLEN-1:0]  pc2, pc4, pc8;
   logic [XLEN-1:0]  a, b, reg_b, st_data;
   logic [63:0]      rot_wide;
   logic [4:0]       rot;
   logic [XLEN:0]    sum;
   logic [XLEN-1:0]  diff;
   logic             add_v, sub_v, sub_c;
   logic [XLEN-1:0]  br_off, t_off, mem_off;
   logic [XLEN-1:0]  alu_res;
   logic             alu_wr;

   assign w   = instruction;
   assign rn  = w[19:16];
   assign rd  = w[15:12];
   assign rm  = w[3:0];
   assign op  = w[24:21];
   assign pc2 = pc + 32'd2;
   assign pc4 = pc + 32'd4;
   assign pc8 = pc + 32'd8;

   assign a       = (rn == PC_IDX) ? pc8 : opa;
   assign reg_b   = (rm == PC_IDX) ? pc8 : opb;
   assign st_data = (rd == PC_IDX) ? pc8 : opb;

   assign rot      = {w[11:8], 1'b0};
   assign rot_wide = {24'd0, w[7:0], 24'd0, w[7:0]} >> rot;
   assign b        = w[25] ? rot_wide[XLEN-1:0] : reg_b;

   assign sum   = {1'b0, a} + {1'b0, b};
   assign diff  = a - b;
   assign add_v = (~(a[31] ^ b[31])) & (a[31] ^ sum[31]);
   assign sub_v = (a[31] ^ b[31]) & (a[31] ^ diff[31]);
   assign sub_c = (a >= b);

   assign br_off  = {{6{w[23]}}, w[23:0], 2'b00};
   assign t_off   = {{20{w[10]}}, w[10:0], 1'b0};
   assign mem_off = {20'd0, w[11:0]};

   always_comb begin
      rsp              = '0;
      upd.pc           = pc;
      upd.flags        = flags;
      upd.thumb        = thumb;
      upd.load_pending = load_pending;
      upd.load_dest    = load_dest;
      upd.rf_we        = 1'b0;
      upd.rf_waddr     = rd;
      upd.rf_wdata     = load_data;
      alu_res          = '0;
      alu_wr           = 1'b0;

      if (req_type == REQ_DATA) begin
         if (!load_pending) begin
            rsp.protocol_error = 1'b1;
         end else begin
            upd.load_pending = 1'b0;
            if (load_dest == PC_IDX) begin
               upd.thumb = load_data[0];
               upd.pc    = {load_data[XLEN-1:1], 1'b0};
            end else begin
               upd.rf_we    = 1'b1;
               upd.rf_waddr = load_dest;
               upd.rf_wdata = load_data;
            end
         end
         rsp.cycle_cost = COST_NONE;
      end else if (load_pending) begin
         rsp.protocol_error = 1'b1;
         rsp.cycle_cost     = COST_NONE;
      end else if (thumb) begin
         if (w[15:8] == T_SVC_HI) begin
            upd.pc          = pc2;
            rsp.svc_request = 1'b1;
            rsp.svc_number  = {16'd0, w[7:0]};
            rsp.cycle_cost  = COST_NORMAL;
         end else if (w[15:11] == T_B_HI) begin
            upd.pc         = pc4 + t_off;
            rsp.cycle_cost = COST_MEM;
         end else begin
            upd.pc         = pc2;
            rsp.cycle_cost = COST_NORMAL;
         end
      end else if (!cond_pass(w[31:28], flags)) begin
         upd.pc         = pc4;
         rsp.cycle_cost = COST_NORMAL;
      end else if ((w & SVC_MASK) == SVC_MASK) begin
         upd.pc          = pc4;
         rsp.svc_request = 1'b1;
         rsp.svc_number  = w[SVC_W-1:0];
         rsp.cycle_cost  = COST_NORMAL;
      end else if ((w & BR_MASK) == BR_PATT) begin
         if (w[24]) begin
            upd.rf_we    = 1'b1;
            upd.rf_waddr = LR_IDX;
            upd.rf_wdata = pc4;
         end
         upd.pc         = pc8 + br_off;
         rsp.cycle_cost = COST_BRANCH;
      end else if ((w & BX_MASK) == BX_PATT) begin
         if (w[5]) begin
            upd.rf_we    = 1'b1;
            upd.rf_waddr = LR_IDX;
            upd.rf_wdata = pc4;
         end
         upd.thumb      = reg_b[0];
         upd.pc         = {reg_b[XLEN-1:1], 1'b0};
         rsp.cycle_cost = COST_BRANCH;
      end else if ((w & CLS_MASK) == '0) begin
         case (op)
            OP_ADD: begin
               alu_res = sum[XLEN-1:0];
               alu_wr  = 1'b1;
               if (w[20]) begin
                  upd.flags = {sum[31], (sum[XLEN-1:0] == '0), sum[XLEN], add_v};
               end
            end
            OP_SUB: begin
               alu_res = diff;
               alu_wr  = 1'b1;
               if (w[20]) begin
                  upd.flags = {diff[31], (diff == '0), sub_c, sub_v};
               end
            end
            OP_MOV: begin
               alu_res = b;
               alu_wr  = 1'b1;
               if (w[20]) begin
                  upd.flags = {b[31], (b == '0), flags[1:0]};
               end
            end
            OP_CMP: begin
               upd.flags = {diff[31], (diff == '0), sub_c, sub_v};
            end
            default: begin
               alu_wr = 1'b0;
            end
         endcase
         if (alu_wr && rd == PC_IDX) begin
            upd.pc = alu_res;
         end else begin
            upd.pc       = pc4;
            upd.rf_we    = alu_wr;
            upd.rf_waddr = rd;
            upd.rf_wdata = alu_res;
         end
         rsp.cycle_cost = COST_NORMAL;
      end else if ((w & CLS_MASK) == MEM_PATT) begin
         rsp.mem_address = w[23] ? (a + mem_off) : (a - mem_off);
         if (w[20]) begin
            rsp.mem_read     = 1'b1;
            upd.load_pending = 1'b1;
            upd.load_dest    = rd;
         end else begin
            rsp.mem_write  = 1'b1;
            rsp.store_data = st_data;
         end
         upd.pc         = pc4;
         rsp.cycle_cost = COST_MEM;
      end else begin
         upd.pc         = pc4;
         rsp.cycle_cost = COST_NORMAL;
      end

      rsp.next_pc    = upd.pc;
      rsp.thumb_mode = upd.thumb;
      rsp.flags_nzcv = upd.flags;
   end

endmodule

// ----- src/arm_subset_instruction_execute.sv -----
// top level of the arm subset execute block: input register, register file,
// execute logic and response register; depends on asie_pkg, asie_if, asie_ram, asie_exec
`timescale 1ns / 1ps

// usage
// req_chan carries one word per item: an instruction to execute (req_type 0)
// or the data for an outstanding load (req_type 1); rsp_chan returns exactly
// one word per item with the next pc, thumb bit, cost, memory request,
// supervisor call and flags
// the word is captured together with its register file reads, then
// executed into the rsp register while the architectural state updates
// at the same edge
// throughput is one word per cycle while rsp ready stays high; the
// register file ram reads at accept, and a write from the word ahead is
// forwarded into the captured operands
// a load returns its request and the next instruction word is dropped with
// protocol_error until a data word arrives
// synchronous reset clears pc, flags, thumb bit, load tracking and the
// register file valid bits, so every register reads as zero; req ready is low
// during reset
// when rsp ready is low the rsp word holds, one more word waits in the
// input register, and req ready then drops

module arm_subset_instruction_execute import asie_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   asie_req_if.sink   req_chan,
   asie_rsp_if.source rsp_chan
);

   logic             in_valid_ff;
   logic             in_type_ff;
   logic [XLEN-1:0]  in_instr_ff;
   logic [XLEN-1:0]  in_data_ff;
   logic [RF_AW-1:0] addr_a_ff, addr_b_ff;
   logic             byp_a_ff, byp_b_ff;
   logic [XLEN-1:0]  byp_data_ff;

   logic [XLEN-1:0]  pc_ff;
   logic [3:0]       flags_ff;
   logic             thumb_ff;
   logic             load_pending_ff;
   logic [RF_AW-1:0] load_dest_ff;
   logic [15:0]      rf_valid_ff;

   logic             out_valid_ff;
   rsp_word_type     rsp_ff;

   logic             accept, fire, is_store;
   logic [RF_AW-1:0] raddr_a, raddr_b;
   logic [XLEN-1:0]  q_a, q_b, opa, opb;
   rsp_word_type     rsp_in;
   state_upd_type    upd;

   assign fire           = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !reset && (!in_valid_ff || fire);
   assign accept         = req_chan.valid && req_chan.ready;

   assign is_store = (req_chan.instruction[27:26] == 2'b01) && !req_chan.instruction[20];
   assign raddr_a  = req_chan.instruction[19:16];
   assign raddr_b  = is_store ? req_chan.instruction[15:12] : req_chan.instruction[3:0];

   asie_ram #(
      .WIDTH (XLEN),
      .DEPTH (16)
   ) u_rf (
      .clock   (clock),
      .we      (fire && upd.rf_we),
      .waddr   (upd.rf_waddr),
      .wdata   (upd.rf_wdata),
      .re      (accept),
      .raddr_a (raddr_a),
      .raddr_b (raddr_b),
      .rdata_a (q_a),
      .rdata_b (q_b)
   );

   assign opa = byp_a_ff ? byp_data_ff : (rf_valid_ff[addr_a_ff] ? q_a : '0);
   assign opb = byp_b_ff ? byp_data_ff : (rf_valid_ff[addr_b_ff] ? q_b : '0);

   asie_exec u_exec (
      .req_type     (in_type_ff),
      .instruction  (in_instr_ff),
      .load_data    (in_data_ff),
      .opa          (opa),
      .opb          (opb),
      .pc           (pc_ff),
      .flags        (flags_ff),
      .thumb        (thumb_ff),
      .load_pending (load_pending_ff),
      .load_dest    (load_dest_ff),
      .rsp          (rsp_in),
      .upd          (upd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         pc_ff           <= '0;
         flags_ff        <= '0;
         thumb_ff        <= 1'b0;
         load_pending_ff <= 1'b0;
         load_dest_ff    <= '0;
         rf_valid_ff     <= '0;
      end else begin
         if (accept) begin
            in_valid_ff <= 1'b1;
         end else if (fire) begin
            in_valid_ff <= 1'b0;
         end
         if (fire) begin
            out_valid_ff    <= 1'b1;
            pc_ff           <= upd.pc;
            flags_ff        <= upd.flags;
            thumb_ff        <= upd.thumb;
            load_pending_ff <= upd.load_pending;
            load_dest_ff    <= upd.load_dest;
            if (upd.rf_we) begin
               rf_valid_ff[upd.rf_waddr] <= 1'b1;
            end
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_type_ff  <= req_chan.req_type;
         in_instr_ff <= req_chan.instruction;
         in_data_ff  <= req_chan.load_data;
         addr_a_ff   <= raddr_a;
         addr_b_ff   <= raddr_b;
         byp_a_ff    <= fire && upd.rf_we && (upd.rf_waddr == raddr_a);
         byp_b_ff    <= fire && upd.rf_we && (upd.rf_waddr == raddr_b);
         byp_data_ff <= upd.rf_wdata;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.next_pc        = rsp_ff.next_pc;
   assign rsp_chan.thumb_mode     = rsp_ff.thumb_mode;
   assign rsp_chan.cycle_cost     = rsp_ff.cycle_cost;
   assign rsp_chan.mem_read       = rsp_ff.mem_read;
   assign rsp_chan.mem_write      = rsp_ff.mem_write;
   assign rsp_chan.mem_address    = rsp_ff.mem_address;
   assign rsp_chan.store_data     = rsp_ff.store_data;
   assign rsp_chan.svc_request    = rsp_ff.svc_request;
   assign rsp_chan.svc_number     = rsp_ff.svc_number;
   assign rsp_chan.flags_nzcv     = rsp_ff.flags_nzcv;
   assign rsp_chan.protocol_error = rsp_ff.protocol_error;

`ifndef SYNTHESIS
   a_err_no_cost: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.protocol_error) |->
      (rsp_chan.cycle_cost == COST_NONE && !rsp_chan.mem_read && !rsp_chan.mem_write))
      else $error("protocol error word carries cost or memory request");

   a_read_pending: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.mem_read) |-> load_pending_ff)
      else $error("load request shown without pending load");

   a_one_request: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !(rsp_chan.mem_read && rsp_chan.mem_write))
      else $error("read and write requested together");

   a_no_pc_write: assert property (@(posedge clock) disable iff (reset)
      (fire && upd.rf_we) |-> (upd.rf_waddr != PC_IDX))
      else $error("register file write aimed at pc entry");
`endif

endmodule
